// ----- design/frsp_pkg.sv -----
// frsp_pkg: shared constants and the prime table for the fraction reducer
// no dependencies; imported by frsp_div, fraction_reducer_small_primes and the testbench
`default_nettype none

package frsp_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 32;
    localparam int PRIME_COUNT         = 12;
    localparam int PRIME_IDX_W         = 4;
    localparam int PRIME_W             = 6;

    typedef logic [PRIME_IDX_W-1:0] prime_idx_t;
    typedef logic [PRIME_W-1:0]     prime_t;

    // status of the shared divider, valid in the cycle that done is high
    typedef struct packed {
        logic done;
        logic a_exact;
        logic b_exact;
    } div_status_t;

    function automatic prime_t prime_at(input prime_idx_t idx);
        prime_t p;
        case (idx)
            4'd0:    p = 6'd2;
            4'd1:    p = 6'd3;
            4'd2:    p = 6'd5;
            4'd3:    p = 6'd7;
            4'd4:    p = 6'd11;
            4'd5:    p = 6'd13;
            4'd6:    p = 6'd17;
            4'd7:    p = 6'd19;
            4'd8:    p = 6'd23;
            4'd9:    p = 6'd29;
            4'd10:   p = 6'd31;
            4'd11:   p = 6'd37;
            default: p = 6'd37;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- design/frsp_div.sv -----
// frsp_div: two-lane bit-serial restoring divider by a small prime
// depends on frsp_pkg; one quotient bit per lane per cycle
`default_nettype none

module frsp_div
    import frsp_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire prime_t                 divisor,
    input  wire logic [VALUE_WIDTH-1:0] dividend_a,
    input  wire logic [VALUE_WIDTH-1:0] dividend_b,
    output logic      [VALUE_WIDTH-1:0] quotient_a,
    output logic      [VALUE_WIDTH-1:0] quotient_b,
    output div_status_t                 status
);

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] a_reg, a_next;
    logic [VALUE_WIDTH-1:0] b_reg, b_next;
    prime_t                 ra_reg, ra_next;
    prime_t                 rb_reg, rb_next;
    prime_t                 div_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   run_reg;
    logic                   done_reg;

    logic [PRIME_W:0] ta, tb;
    logic             ge_a, ge_b;

    // one restoring step per lane; the quotient bit shifts in where the dividend leaves
    always_comb
    begin
        ta      = {ra_reg, a_reg[VALUE_WIDTH-1]};
        tb      = {rb_reg, b_reg[VALUE_WIDTH-1]};
        ge_a    = (ta >= {1'b0, div_reg});
        ge_b    = (tb >= {1'b0, div_reg});
        ra_next = ge_a ? PRIME_W'(ta - {1'b0, div_reg}) : PRIME_W'(ta);
        rb_next = ge_b ? PRIME_W'(tb - {1'b0, div_reg}) : PRIME_W'(tb);
        a_next  = {a_reg[VALUE_WIDTH-2:0], ge_a};
        b_next  = {b_reg[VALUE_WIDTH-2:0], ge_b};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(VALUE_WIDTH);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= dividend_a;
            b_reg   <= dividend_b;
            ra_reg  <= '0;
            rb_reg  <= '0;
            div_reg <= divisor;
        end
        else if (run_reg)
        begin
            a_reg  <= a_next;
            b_reg  <= b_next;
            ra_reg <= ra_next;
            rb_reg <= rb_next;
        end
    end

    assign quotient_a     = a_reg;
    assign quotient_b     = b_reg;
    assign status.done    = done_reg;
    assign status.a_exact = (ra_reg == '0);
    assign status.b_exact = (rb_reg == '0);

endmodule

`default_nettype wire

// ----- design/fraction_reducer_small_primes.sv -----
// fraction_reducer_small_primes: top level, sign handling and prime sequencer
// depends on frsp_pkg and frsp_div
//
// usage: present numerator and denominator and raise start while busy is low;
// the word is taken at that edge and busy rises in the next cycle, except for
// 0/0, which never raises busy.
// the block strips the primes 2 to 37 that both magnitudes share, keeping
// each sign, and gives reduced_numerator and reduced_denominator with done
// high for exactly one cycle; the receiver cannot hold the result off.
// busy is low again in the cycle that done is high, so a new word may be
// started then.
// 0/0 is returned unchanged; otherwise every divisibility test is one pass of
// the shared two-lane serial divider, and a fraction needs at most about 44
// tests at 32 bits. one word is in work at a time.
// reset: busy and done drop at once, any word in work is lost.
`default_nettype none

module fraction_reducer_small_primes
    import frsp_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [VALUE_WIDTH-1:0] numerator,
    input  wire logic [VALUE_WIDTH-1:0] denominator,
    output logic                        busy,
    output logic                        done,
    output logic      [VALUE_WIDTH-1:0] reduced_numerator,
    output logic      [VALUE_WIDTH-1:0] reduced_denominator
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LAUNCH,
        S_WAIT
    } state_t;

    state_t                 state_reg;
    prime_idx_t             idx_reg;
    logic [VALUE_WIDTH-1:0] nmag_reg;
    logic [VALUE_WIDTH-1:0] dmag_reg;
    logic                   nneg_reg;
    logic                   dneg_reg;
    logic                   done_reg;
    logic [VALUE_WIDTH-1:0] rnum_reg;
    logic [VALUE_WIDTH-1:0] rden_reg;

    logic [VALUE_WIDTH-1:0] nmag_in, dmag_in;
    logic [VALUE_WIDTH-1:0] qa, qb;
    div_status_t            dstat;
    logic                   accept;
    logic                   last_prime;

    // magnitude fits VALUE_WIDTH bits unsigned, even for the most negative value
    assign nmag_in = numerator[VALUE_WIDTH-1]   ? (~numerator + VALUE_WIDTH'(1))   : numerator;
    assign dmag_in = denominator[VALUE_WIDTH-1] ? (~denominator + VALUE_WIDTH'(1)) : denominator;

    assign accept     = start && (state_reg == S_IDLE);
    assign last_prime = (idx_reg == PRIME_IDX_W'(PRIME_COUNT - 1));

    frsp_div #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (state_reg == S_LAUNCH),
        .divisor    (prime_at(idx_reg)),
        .dividend_a (nmag_reg),
        .dividend_b (dmag_reg),
        .quotient_a (qa),
        .quotient_b (qb),
        .status     (dstat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            idx_reg   <= '0;
            nmag_reg  <= '0;
            dmag_reg  <= '0;
            nneg_reg  <= 1'b0;
            dneg_reg  <= 1'b0;
            rnum_reg  <= '0;
            rden_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        nmag_reg <= nmag_in;
                        dmag_reg <= dmag_in;
                        nneg_reg <= numerator[VALUE_WIDTH-1];
                        dneg_reg <= denominator[VALUE_WIDTH-1];
                        idx_reg  <= '0;
                        if ((nmag_in == '0) && (dmag_in == '0))
                        begin
                            // zero over zero would divide for ever
                            rnum_reg <= numerator;
                            rden_reg <= denominator;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_LAUNCH;
                        end
                    end
                end
                S_LAUNCH:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (dstat.done)
                    begin
                        if (dstat.a_exact && dstat.b_exact)
                        begin
                            // both divisible: take quotients, try the same prime again
                            nmag_reg  <= qa;
                            dmag_reg  <= qb;
                            state_reg <= S_LAUNCH;
                        end
                        else if (last_prime || (!dneg_reg && (dmag_reg == VALUE_WIDTH'(1))))
                        begin
                            rnum_reg  <= nneg_reg ? (~nmag_reg + VALUE_WIDTH'(1)) : nmag_reg;
                            rden_reg  <= dneg_reg ? (~dmag_reg + VALUE_WIDTH'(1)) : dmag_reg;
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + PRIME_IDX_W'(1);
                            state_reg <= S_LAUNCH;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy                = (state_reg != S_IDLE);
    assign done                = done_reg;
    assign reduced_numerator   = rnum_reg;
    assign reduced_denominator = rden_reg;

endmodule

`default_nettype wire

// ----- tb/sv/fraction_reducer_small_primes_test.sv -----
`timescale 1ns / 1ps
// fraction_reducer_small_primes_test: drives fractions into the reducer and checks each
// reduced pair against a sign and magnitude trial division predictor held in a scoreboard
// depends on frsp_pkg and fraction_reducer_small_primes

module fraction_reducer_small_primes_test;
    import frsp_pkg::*;

    localparam int W            = DEFAULT_VALUE_WIDTH;
    localparam int QUIET_LIMIT  = 8000;
    localparam int RANDOM_WORDS = 350;
    localparam int MAX_REPORTS  = 10;

    typedef logic [W-1:0] value_t;

    typedef struct packed {
        value_t num;
        value_t den;
    } fraction_t;

    typedef struct packed {
        fraction_t src;
        fraction_t res;
    } reduction_t;

    localparam value_t MOST_NEG = {1'b1, {(W-1){1'b0}}};
    localparam value_t MOST_POS = ~MOST_NEG;

    class reduction_scoreboard;
        reduction_t pending_reductions[$];
        int unsigned primes[PRIME_COUNT];
        int mismatches;

        function new();
            mismatches = 0;
            primes = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
        endfunction

        // strip the shared small primes, working on magnitudes so signs survive
        function fraction_t reduce_fraction(fraction_t f);
            logic n_neg;
            logic d_neg;
            value_t n_mag;
            value_t d_mag;
            fraction_t r;
            int i;
            n_neg = f.num[W-1];
            d_neg = f.den[W-1];
            n_mag = n_neg ? value_t'(0) - f.num : f.num;
            d_mag = d_neg ? value_t'(0) - f.den : f.den;
            if (n_mag != 0 || d_mag != 0)
            begin
                for (i = 0; i < PRIME_COUNT; i++)
                begin
                    while (n_mag % primes[i] == 0 && d_mag % primes[i] == 0)
                    begin
                        n_mag = n_mag / primes[i];
                        d_mag = d_mag / primes[i];
                    end
                    if (!d_neg && d_mag == 1)
                        break;
                end
            end
            r.num = n_neg ? value_t'(0) - n_mag : n_mag;
            r.den = d_neg ? value_t'(0) - d_mag : d_mag;
            return r;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endfunction

        function void note_word(value_t n, value_t d);
            reduction_t e;
            e.src.num = n;
            e.src.den = d;
            e.res = reduce_fraction(e.src);
            pending_reductions.push_back(e);
        endfunction

        function void check_word(value_t n, value_t d);
            reduction_t e;
            if (pending_reductions.size() == 0)
            begin
                flag($sformatf("result %0d/%0d with no word outstanding",
                               $signed(n), $signed(d)));
                return;
            end
            e = pending_reductions.pop_front();
            if (n !== e.res.num)
                flag($sformatf("reduced_numerator for %0d/%0d: expected %0d, got %0d",
                               $signed(e.src.num), $signed(e.src.den),
                               $signed(e.res.num), $signed(n)));
            if (d !== e.res.den)
                flag($sformatf("reduced_denominator for %0d/%0d: expected %0d, got %0d",
                               $signed(e.src.num), $signed(e.src.den),
                               $signed(e.res.den), $signed(d)));
        endfunction

        function int outstanding();
            return pending_reductions.size();
        endfunction
    endclass

    logic   clk;
    logic   rst_n       = 1'b0;
    logic   start       = 1'b0;
    value_t numerator   = '0;
    value_t denominator = '0;
    logic   busy;
    logic   done;
    value_t reduced_numerator;
    value_t reduced_denominator;

    reduction_scoreboard board;
    int quiet_cycles = 0;
    int burst_left   = 0;

    fraction_reducer_small_primes #(
        .VALUE_WIDTH (W)
    ) dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .numerator           (numerator),
        .denominator         (denominator),
        .busy                (busy),
        .done                (done),
        .reduced_numerator   (reduced_numerator),
        .reduced_denominator (reduced_denominator)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            board.check_word(reduced_numerator, reduced_denominator);
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // hold the word until it is taken; start stays high for a following word
    task automatic send_word(value_t n, value_t d);
        start       <= 1'b1;
        numerator   <= n;
        denominator <= d;
        do @(posedge clk); while (busy);
        board.note_word(n, d);
    endtask

    // gap with start low, sometimes timed from the end of the current word
    task automatic rest();
        start <= 1'b0;
        if ($urandom_range(0, 2) == 0)
        begin
            do @(posedge clk); while (busy);
            repeat ($urandom_range(0, 5)) @(posedge clk);
        end
        else
            repeat ($urandom_range(1, 40)) @(posedge clk);
    endtask

    task automatic issue(value_t n, value_t d);
        send_word(n, d);
        if (burst_left == 0)
        begin
            rest();
            burst_left = ($urandom_range(0, 7) == 0) ? 20 : $urandom_range(0, 5);
        end
        else
            burst_left--;
    endtask

    function automatic longint unsigned grow(longint unsigned base, int steps,
                                             longint unsigned cap);
        longint unsigned p;
        repeat (steps)
        begin
            p = board.primes[$urandom_range(0, PRIME_COUNT - 1)];
            if (base * p <= cap)
                base = base * p;
        end
        return base;
    endfunction

    function automatic value_t signed_value(longint unsigned mag, logic neg);
        return neg ? value_t'(0) - value_t'(mag) : value_t'(mag);
    endfunction

    function automatic value_t special_value();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return value_t'(1);
            2:       return value_t'(-1);
            3:       return MOST_NEG;
            4:       return MOST_POS;
            default: return value_t'($urandom);
        endcase
    endfunction

    // pair sharing a smooth common factor, with a random cofactor on each side
    task automatic issue_smooth_pair();
        longint unsigned common;
        longint unsigned n_mag;
        longint unsigned d_mag;
        longint unsigned n_cap;
        longint unsigned d_cap;
        logic n_neg;
        logic d_neg;
        n_neg = $urandom_range(0, 1);
        d_neg = $urandom_range(0, 1);
        n_cap = n_neg ? 64'h8000_0000 : 64'h7fff_ffff;
        d_cap = d_neg ? 64'h8000_0000 : 64'h7fff_ffff;
        common = grow(1, $urandom_range(0, 14), 64'h7fff_ffff);
        n_mag = grow(common, $urandom_range(0, 5), n_cap);
        d_mag = grow(common, $urandom_range(0, 5), d_cap);
        if ($urandom_range(0, 3) == 0)
            n_mag = n_mag * $urandom_range(1, int'(n_cap / n_mag));
        if ($urandom_range(0, 3) == 0)
            d_mag = d_mag * $urandom_range(1, int'(d_cap / d_mag));
        issue(signed_value(n_mag, n_neg), signed_value(d_mag, d_neg));
    endtask

    initial
    begin
        int pick;
        board = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero over zero, one side zero, the extremes, every sign pairing
        issue('0, '0);
        issue('0, value_t'(5));
        issue(value_t'(7), '0);
        issue('0, value_t'(-12));
        issue('0, MOST_NEG);
        issue(MOST_NEG, '0);
        issue(MOST_NEG, MOST_NEG);
        issue(MOST_NEG, value_t'(2));
        issue(MOST_POS, MOST_POS);
        issue(MOST_POS, MOST_NEG);
        issue(value_t'(12), value_t'(18));
        issue(value_t'(-12), value_t'(18));
        issue(value_t'(12), value_t'(-18));
        issue(value_t'(-12), value_t'(-18));
        issue(value_t'(1), value_t'(1));
        issue(value_t'(-1), value_t'(-1));
        issue(value_t'(1), value_t'(-1));
        issue(value_t'(223092870), value_t'(223092870));
        issue(value_t'(69343957), value_t'(1874161));
        issue(value_t'(74), value_t'(37));
        issue(value_t'(6), value_t'(2));
        issue(value_t'(32'h4000_0000), value_t'(32'h6000_0000));
        issue(value_t'(-1073741824), value_t'(1610612736));

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
                issue(value_t'($urandom), value_t'($urandom));
            else if (pick < 22)
                issue(special_value(), special_value());
            else
                issue_smooth_pair();
        end
        start <= 1'b0;

        while (board.outstanding() != 0) @(posedge clk);
        repeat (64) @(posedge clk);
        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
